// ----- rtl/gfp_pkg.sv -----
package gfp_pkg;

   localparam int GRID_MAX_WIDTH_DEF  = 16;
   localparam int GRID_MAX_HEIGHT_DEF = 16;

   localparam int CFG_W    = 5;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W     = 2;
   localparam int POS_W    = 4;
   localparam int RECT_W   = 5;

   localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

endpackage

// ----- rtl/gfp_ram.sv -----
module gfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/grid_first_fit_placement_core.sv -----
// steps: a write reads the row, then writes it back modified; a check gathers its row band, then
//   makes one mask compare; an unused opcode or rejected size is answered straight from idle
// find: gathers each candidate row band through the row ram, then tries one column per cycle
//   in the shared mask compare
// throughput: one item at a time, busy high until the result strobe; a new item may start
//   in the cycle that rsp_valid is shown, and the result is never held off
// reset: synchronous, active high; all cells free, grid size 16 by 16, no result pending
module grid_first_fit_placement_core
   import gfp_pkg::*;
#(
   parameter int GRID_MAX_WIDTH  = GRID_MAX_WIDTH_DEF,
   parameter int GRID_MAX_HEIGHT = GRID_MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [RECT_W-1:0]    req_rect_width,
   input  logic [RECT_W-1:0]    req_rect_height,
   input  logic                 req_cell_value,
   output logic                 rsp_valid,
   output logic                 rsp_fits,
   output logic [POS_W-1:0]     rsp_place_x,
   output logic [POS_W-1:0]     rsp_place_y,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int XW   = $clog2(GRID_MAX_WIDTH);
   localparam int YW   = $clog2(GRID_MAX_HEIGHT);
   localparam int KW   = $clog2(GRID_MAX_HEIGHT + 1);
   localparam int MAXD = (GRID_MAX_WIDTH > GRID_MAX_HEIGHT) ? GRID_MAX_WIDTH : GRID_MAX_HEIGHT;
   localparam int SW   = $clog2(MAXD + (1 << RECT_W)) + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ROWS = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_WRD  = 5'b01000,
      ST_WMOD = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [OP_W-1:0]             op_ff, op_in;
   logic [POS_W-1:0]            px_ff, px_in;
   logic [POS_W-1:0]            py_ff, py_in;
   logic [RECT_W-1:0]           w_ff, w_in;
   logic [RECT_W-1:0]           h_ff, h_in;
   logic                        v_ff, v_in;
   logic [XW-1:0]               x_ff, x_in;
   logic [YW-1:0]               y_ff, y_in;
   logic [KW-1:0]               k_ff, k_in;
   logic                        pend_ff, pend_in;
   logic [GRID_MAX_WIDTH-1:0]   or_ff, or_in;
   logic [CFG_W-1:0]            grid_width_ff, grid_height_ff;
   logic [GRID_MAX_HEIGHT-1:0]  row_valid_ff;
   logic                        rd_vld_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_fits_ff, rsp_fits_in;
   logic [POS_W-1:0]            rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]            rsp_y_ff, rsp_y_in;

   logic [YW-1:0]               ram_rd_addr;
   logic [GRID_MAX_WIDTH-1:0]   ram_rd_data;
   logic                        ram_wr_en;
   logic [GRID_MAX_WIDTH-1:0]   ram_wr_data;

   logic [SW-1:0]               gw, gh;
   logic [GRID_MAX_WIDTH-1:0]   rd_row;
   logic [GRID_MAX_WIDTH-1:0]   wmask;
   logic [GRID_MAX_WIDTH-1:0]   bit_mask;
   logic                        hit;
   logic                        issue;

   gfp_ram #(
      .WIDTH (GRID_MAX_WIDTH),
      .DEPTH (GRID_MAX_HEIGHT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (YW'(py_ff)),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_fits    = rsp_fits_ff;
   assign rsp_place_x = rsp_x_ff;
   assign rsp_place_y = rsp_y_ff;

   // sizes above storage saturate
   assign gw = (SW'(grid_width_ff) > SW'(GRID_MAX_WIDTH)) ? SW'(GRID_MAX_WIDTH)
                                                          : SW'(grid_width_ff);
   assign gh = (SW'(grid_height_ff) > SW'(GRID_MAX_HEIGHT)) ? SW'(GRID_MAX_HEIGHT)
                                                            : SW'(grid_height_ff);

   // a row never written reads as free
   assign rd_row   = ram_rd_data & {GRID_MAX_WIDTH{rd_vld_ff}};
   assign bit_mask = GRID_MAX_WIDTH'(1) << px_ff;
   assign issue    = (SW'(k_ff) < SW'(h_ff));

   always_comb begin
      for (int i = 0; i < GRID_MAX_WIDTH; i++) begin
         wmask[i] = (SW'(i) < SW'(w_ff));
      end
   end

   // shared window compare: band of rows against the rectangle mask at column x
   assign hit = (((or_ff >> x_ff) & wmask) == '0);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      or_in        = or_ff;
      rsp_valid_in = 1'b0;
      rsp_fits_in  = 1'b0;
      rsp_x_in     = px_ff;
      rsp_y_in     = py_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = (rd_row & ~bit_mask) | (v_ff ? bit_mask : '0);
      ram_rd_addr  = YW'(SW'(y_ff) + SW'(k_ff));

      unique case (state_ff)
         ST_IDLE: begin
            rsp_x_in = req_pos_x;
            rsp_y_in = req_pos_y;
            if (start) begin
               op_in = req_opcode;
               px_in = req_pos_x;
               py_in = req_pos_y;
               w_in  = req_rect_width;
               h_in  = req_rect_height;
               v_in  = req_cell_value;
               k_in  = '0;
               or_in = '0;
               unique case (req_opcode)
                  OP_WRITE: begin
                     // cells beyond storage are dropped
                     if ((SW'(req_pos_x) < SW'(GRID_MAX_WIDTH)) &&
                         (SW'(req_pos_y) < SW'(GRID_MAX_HEIGHT))) begin
                        state_in = ST_WRD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CHECK: begin
                     if ((req_rect_width == '0) || (req_rect_height == '0) ||
                         (SW'(req_pos_x) + SW'(req_rect_width) > gw) ||
                         (SW'(req_pos_y) + SW'(req_rect_height) > gh)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        x_in     = XW'(req_pos_x);
                        y_in     = YW'(req_pos_y);
                        state_in = ST_ROWS;
                     end
                  end
                  OP_FIND: begin
                     if ((req_rect_width == '0) || (req_rect_height == '0) ||
                         (SW'(req_rect_width) > gw) || (SW'(req_rect_height) > gh)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        x_in     = '0;
                        y_in     = '0;
                        state_in = ST_ROWS;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ROWS: begin
            // one row read issued per cycle, its data folded in on the next cycle
            if (issue) begin
               k_in    = k_ff + KW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               or_in = or_ff | rd_row;
            end
            if (!issue && pend_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_CHECK) begin
               rsp_valid_in = 1'b1;
               rsp_fits_in  = hit;
               state_in     = ST_IDLE;
            end else if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_fits_in  = 1'b1;
               rsp_x_in     = POS_W'(x_ff);
               rsp_y_in     = POS_W'(y_ff);
               state_in     = ST_IDLE;
            end else if (SW'(x_ff) + SW'(w_ff) < gw) begin
               x_in = x_ff + XW'(1);
            end else if (SW'(y_ff) + SW'(h_ff) < gh) begin
               y_in     = y_ff + YW'(1);
               x_in     = '0;
               k_in     = '0;
               or_in    = '0;
               state_in = ST_ROWS;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WRD: begin
            ram_rd_addr = YW'(py_ff);
            state_in    = ST_WMOD;
         end
         ST_WMOD: begin
            ram_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         row_valid_ff   <= '0;
         grid_width_ff  <= GRID_SIZE_RESET;
         grid_height_ff <= GRID_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            row_valid_ff[YW'(py_ff)] <= 1'b1;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      v_ff        <= v_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      or_ff       <= or_in;
      rd_vld_ff   <= row_valid_ff[ram_rd_addr];
      rsp_fits_ff <= rsp_fits_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

`ifndef NO_ASSERTIONS
   // an accepted item either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither answered nor in progress");

   // the row band is complete before any column is tested
   a_scan_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !pend_ff)
      else $error("column scan started with a row read outstanding");

   // rows gathered never exceed the rectangle height
   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROWS |-> SW'(k_ff) <= SW'(h_ff))
      else $error("row counter ran past rectangle height");

   // a write never reports a fit
   a_write_no_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fits |-> op_ff == OP_CHECK || op_ff == OP_FIND)
      else $error("fit reported for a write or unused opcode");

   // a result is only produced when the block returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff != ST_WMOD && state_ff != ST_WRD)
      else $error("result strobe while a write is still in progress");
`endif

endmodule
